// File: rtl/tangent_circle_placer_macros.svh
// Assertion macros for the tangent circle placer RTL.
// Expects clk_i and rst_ni in the scope of each use; no other dependencies.
`ifndef TANGENT_CIRCLE_PLACER_MACROS_SVH
`define TANGENT_CIRCLE_PLACER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TCP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tangent_circle_placer: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define TCP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tangent_circle_placer: next-cycle check failed");

`endif

// File: rtl/tcp_pkg.sv
// Shared widths, stage indices, types and status codes of the tangent circle placer.
// No dependencies; used by tcp_div, tcp_sqrt and tangent_circle_placer.
package tcp_pkg;

  localparam int CoordW   = 32;
  localparam int RadW     = 31;
  localparam int UnitBits = 30;
  localparam int XW       = CoordW + 2;

  localparam int DvdW = 63;
  localparam int DivW = 32;
  localparam int QuoW = 31;

  localparam int RadicW = 64;
  localparam int RootW  = 32;
  localparam int RemW   = 34;

  localparam int DivStages  = QuoW;
  localparam int SqrtStages = RootW;

  localparam int StIn   = 1;
  localparam int StMul  = 2;
  localparam int StPre  = 3;
  localparam int StT    = StPre + DivStages;
  localparam int StA    = StPre + SqrtStages;
  localparam int StM1   = StA + 1;
  localparam int StM2   = StA + 2;
  localparam int StY    = StM2 + SqrtStages;
  localparam int StU    = StA + DivStages;
  localparam int UDly   = StY - StU;
  localparam int StR1   = StY + 1;
  localparam int StR2   = StY + 2;
  localparam int StR3   = StY + 3;
  localparam int StLast = StY + 4;

  localparam logic signed [CoordW-1:0] CoordMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic signed [CoordW-1:0] CoordMin = {1'b1, {(CoordW-1){1'b0}}};

  typedef enum logic [1:0] {
    StatOk    = 2'd0,
    StatDegen = 2'd1,
    StatClamp = 2'd2,
    StatSat   = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
    logic [RadW-1:0]          p;
    logic [RadW-1:0]          q;
    logic [RadW-1:0]          ux;
    logic [RadW-1:0]          uy;
    logic                     p_ge_n;
    logic                     dx_neg;
    logic                     dy_neg;
    logic                     cw;
    logic                     degen;
    logic                     clamp;
    logic signed [XW-1:0]     x;
  } side_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    status_e                  status;
  } res_t;

endpackage

// File: rtl/tcp_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on tcp_pkg; needs dividend >> QuoW below the divisor.
module tcp_div (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [tcp_pkg::DvdW-1:0]    dividend_i,
  input  logic [tcp_pkg::DivW-1:0]    divisor_i,
  output logic [tcp_pkg::QuoW-1:0]    quotient_o
);

  localparam int N = tcp_pkg::DivStages;

  logic [tcp_pkg::DivW-1:0] rem_q [N];
  logic [tcp_pkg::QuoW-1:0] quo_q [N];
  logic [tcp_pkg::QuoW-1:0] dlo_q [N];
  logic [tcp_pkg::DivW-1:0] dvs_q [N];

  logic [tcp_pkg::DivW-1:0] rem_p [N];
  logic [tcp_pkg::QuoW-1:0] quo_p [N];
  logic [tcp_pkg::QuoW-1:0] dlo_p [N];
  logic [tcp_pkg::DivW-1:0] dvs_p [N];

  logic [tcp_pkg::DivW-1:0] rem_d [N];
  logic [tcp_pkg::QuoW-1:0] quo_d [N];

  always_comb begin
    rem_p[0] = dividend_i[tcp_pkg::DvdW-1:tcp_pkg::QuoW];
    quo_p[0] = '0;
    dlo_p[0] = dividend_i[tcp_pkg::QuoW-1:0];
    dvs_p[0] = divisor_i;
    for (int s = 1; s < N; s++) begin
      rem_p[s] = rem_q[s-1];
      quo_p[s] = quo_q[s-1];
      dlo_p[s] = dlo_q[s-1];
      dvs_p[s] = dvs_q[s-1];
    end
  end

  always_comb begin
    logic [tcp_pkg::DivW:0] r_ext;
    logic [tcp_pkg::DivW:0] r_sub;
    logic                   ge;
    for (int s = 0; s < N; s++) begin
      r_ext    = {rem_p[s], dlo_p[s][tcp_pkg::QuoW-1]};
      r_sub    = r_ext - {1'b0, dvs_p[s]};
      ge       = r_ext >= {1'b0, dvs_p[s]};
      rem_d[s] = ge ? r_sub[tcp_pkg::DivW-1:0] : r_ext[tcp_pkg::DivW-1:0];
      quo_d[s] = {quo_p[s][tcp_pkg::QuoW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < N; s++) begin
        rem_q[s] <= rem_d[s];
        quo_q[s] <= quo_d[s];
        dlo_q[s] <= {dlo_p[s][tcp_pkg::QuoW-2:0], 1'b0};
        dvs_q[s] <= dvs_p[s];
      end
    end
  end

  assign quotient_o = quo_q[N-1];

endmodule

// File: rtl/tcp_sqrt.sv
// Pipelined integer square root, one root bit per stage (floor result).
// Depends on tcp_pkg.
module tcp_sqrt (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [tcp_pkg::RadicW-1:0]   radicand_i,
  output logic [tcp_pkg::RootW-1:0]    root_o
);

  localparam int N = tcp_pkg::SqrtStages;

  logic [tcp_pkg::RemW-1:0]   rem_q  [N];
  logic [tcp_pkg::RootW-1:0]  root_q [N];
  logic [tcp_pkg::RadicW-1:0] rad_q  [N];

  logic [tcp_pkg::RemW-1:0]   rem_p  [N];
  logic [tcp_pkg::RootW-1:0]  root_p [N];
  logic [tcp_pkg::RadicW-1:0] rad_p  [N];

  logic [tcp_pkg::RemW-1:0]   rem_d  [N];
  logic [tcp_pkg::RootW-1:0]  root_d [N];

  always_comb begin
    rem_p[0]  = '0;
    root_p[0] = '0;
    rad_p[0]  = radicand_i;
    for (int s = 1; s < N; s++) begin
      rem_p[s]  = rem_q[s-1];
      root_p[s] = root_q[s-1];
      rad_p[s]  = rad_q[s-1];
    end
  end

  always_comb begin
    logic [tcp_pkg::RemW+1:0] r_in;
    logic [tcp_pkg::RemW+1:0] trial;
    logic [tcp_pkg::RemW+1:0] r_sub;
    logic                     ge;
    for (int s = 0; s < N; s++) begin
      r_in      = {rem_p[s], rad_p[s][tcp_pkg::RadicW-1 -: 2]};
      trial     = {2'b00, root_p[s], 2'b01};
      r_sub     = r_in - trial;
      ge        = r_in >= trial;
      rem_d[s]  = ge ? r_sub[tcp_pkg::RemW-1:0] : r_in[tcp_pkg::RemW-1:0];
      root_d[s] = {root_p[s][tcp_pkg::RootW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < N; s++) begin
        rem_q[s]  <= rem_d[s];
        root_q[s] <= root_d[s];
        rad_q[s]  <= {rad_p[s][tcp_pkg::RadicW-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[N-1];

endmodule

// File: rtl/tangent_circle_placer.sv
// Top level of the tangent circle placer: input stage, law of cosines, rotation.
// Depends on tcp_pkg, tcp_div, tcp_sqrt and tangent_circle_placer_macros.svh.
//
// Takes one placement per clock while in_ready_o is high and returns the center
// of a circle tangent to the pivot and neighbor circles, all coordinates in
// signed Q16.16. The pipeline depth is set by two chains in series: a 31-stage
// divider for the along-axis offset feeding a 32-stage root for the
// across-axis offset, with the distance root and the two unit-vector dividers
// running beside them. Degenerate inputs return the pivot with status 1;
// coordinates that overflow saturate with status 3. When the output is held,
// one more result is caught in a skid register and in_ready_o then drops.
`include "tangent_circle_placer_macros.svh"

module tangent_circle_placer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [tcp_pkg::CoordW-1:0]  pivot_x_i,
  input  logic signed [tcp_pkg::CoordW-1:0]  pivot_y_i,
  input  logic signed [tcp_pkg::CoordW-1:0]  neighbor_x_i,
  input  logic signed [tcp_pkg::CoordW-1:0]  neighbor_y_i,
  input  logic        [tcp_pkg::RadW-1:0]    pivot_rad_i,
  input  logic        [tcp_pkg::RadW-1:0]    neighbor_rad_i,
  input  logic        [tcp_pkg::RadW-1:0]    new_rad_i,
  input  logic                               clockwise_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [tcp_pkg::CoordW-1:0]  new_x_o,
  output logic signed [tcp_pkg::CoordW-1:0]  new_y_o,
  output logic        [1:0]                  status_o
);

  localparam int CW   = tcp_pkg::CoordW;
  localparam int RW   = tcp_pkg::RadW;
  localparam int XW   = tcp_pkg::XW;
  localparam int PW   = 2 * RW + 1;
  localparam int SW   = PW + 2;
  localparam int MagW = SW - tcp_pkg::UnitBits;
  localparam int VW   = MagW + 2;

  logic en;

  logic [tcp_pkg::StLast:tcp_pkg::StIn] vld_q;
  tcp_pkg::side_t side_q [tcp_pkg::StIn:tcp_pkg::StLast];
  tcp_pkg::side_t side_in;
  tcp_pkg::side_t side_a;

  // input stage
  logic signed [CW:0]  dx;
  logic signed [CW:0]  dy;
  logic        [CW:0]  dxm;
  logic        [CW:0]  dym;
  logic                norm_sh;
  logic        [CW-1:0] a_w;
  logic        [RW-1:0] diff_w;

  logic [CW-1:0]     a1_q;
  logic [RW-1:0]     diff1_q;
  logic [CW-1:0]     a2_q;
  logic [2*RW-1:0]   prodt2_q;
  logic [2*RW-1:0]   uxsq2_q;
  logic [2*RW-1:0]   uysq2_q;
  logic [tcp_pkg::DvdW-1:0]   dvd3_q;
  logic [tcp_pkg::DivW-1:0]   dvs3_q;
  logic [tcp_pkg::RadicW-1:0] sumsq3_q;

  assign dx  = $signed({neighbor_x_i[CW-1], neighbor_x_i})
             - $signed({pivot_x_i[CW-1], pivot_x_i});
  assign dy  = $signed({neighbor_y_i[CW-1], neighbor_y_i})
             - $signed({pivot_y_i[CW-1], pivot_y_i});
  assign dxm = dx[CW] ? $unsigned(-dx) : $unsigned(dx);
  assign dym = dy[CW] ? $unsigned(-dy) : $unsigned(dy);
  assign norm_sh = dxm[CW-1] | dym[CW-1];
  assign a_w    = {1'b0, pivot_rad_i} + {1'b0, neighbor_rad_i};
  assign diff_w = (pivot_rad_i >= neighbor_rad_i) ? (pivot_rad_i - neighbor_rad_i)
                                                  : (neighbor_rad_i - pivot_rad_i);

  always_comb begin
    side_in        = '0;
    side_in.px     = pivot_x_i;
    side_in.py     = pivot_y_i;
    side_in.p      = pivot_rad_i;
    side_in.q      = new_rad_i;
    side_in.ux     = norm_sh ? dxm[CW-1:1] : dxm[CW-2:0];
    side_in.uy     = norm_sh ? dym[CW-1:1] : dym[CW-2:0];
    side_in.p_ge_n = pivot_rad_i >= neighbor_rad_i;
    side_in.dx_neg = dx[CW];
    side_in.dy_neg = dy[CW];
    side_in.cw     = clockwise_i;
    side_in.degen  = (a_w == '0) ||
                     ((neighbor_x_i == pivot_x_i) && (neighbor_y_i == pivot_y_i));
  end

  // offset along the axis: x = p + t, then the root factors
  logic [tcp_pkg::QuoW-1:0] tm;
  logic [tcp_pkg::RootW-1:0] dist_root;
  logic signed [XW-1:0] t_s;
  logic signed [XW-1:0] x_w;
  logic signed [XW-1:0] bmx_w;
  logic signed [XW:0]   bpx_w;
  logic                 clamp_w;

  logic [CW-1:0]   bmx_q;
  logic [CW:0]     bpx_q;
  logic [2*CW-1:0] lo1_q;
  logic [CW-1:0]   hi1_q;
  logic [tcp_pkg::RadicW-1:0] rady2_q;

  tcp_div u_div_t (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (dvd3_q),
    .divisor_i  (dvs3_q),
    .quotient_o (tm)
  );

  tcp_sqrt u_sqrt_d (
    .clk_i      (clk_i),
    .en_i       (en),
    .radicand_i (sumsq3_q),
    .root_o     (dist_root)
  );

  always_comb begin
    t_s = side_q[tcp_pkg::StT].p_ge_n ? $signed({{(XW-tcp_pkg::QuoW){1'b0}}, tm})
                                      : -$signed({{(XW-tcp_pkg::QuoW){1'b0}}, tm});
    x_w   = $signed({{(XW-RW){1'b0}}, side_q[tcp_pkg::StT].p}) + t_s;
    bmx_w = $signed({{(XW-RW){1'b0}}, side_q[tcp_pkg::StT].q}) - t_s;
    bpx_w = $signed({{(XW+1-RW){1'b0}}, side_q[tcp_pkg::StT].p})
          + $signed({{(XW+1-RW){1'b0}}, side_q[tcp_pkg::StT].p})
          + $signed({{(XW+1-RW){1'b0}}, side_q[tcp_pkg::StT].q})
          + $signed({t_s[XW-1], t_s});
    clamp_w = bmx_w[XW-1] | bpx_w[XW];
    side_a       = side_q[tcp_pkg::StT];
    side_a.x     = x_w;
    side_a.clamp = clamp_w;
  end

  // unit direction and root of the across-axis term
  logic [tcp_pkg::QuoW-1:0]  cu_quo;
  logic [tcp_pkg::QuoW-1:0]  su_quo;
  logic [tcp_pkg::RootW-1:0] y_root;
  logic [tcp_pkg::QuoW-1:0]  cu_dly_q [tcp_pkg::UDly];
  logic [tcp_pkg::QuoW-1:0]  su_dly_q [tcp_pkg::UDly];

  tcp_div u_div_cu (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i ({2'b00, side_q[tcp_pkg::StA].ux, {tcp_pkg::UnitBits{1'b0}}}),
    .divisor_i  (dist_root),
    .quotient_o (cu_quo)
  );

  tcp_div u_div_su (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i ({2'b00, side_q[tcp_pkg::StA].uy, {tcp_pkg::UnitBits{1'b0}}}),
    .divisor_i  (dist_root),
    .quotient_o (su_quo)
  );

  tcp_sqrt u_sqrt_y (
    .clk_i      (clk_i),
    .en_i       (en),
    .radicand_i (rady2_q),
    .root_o     (y_root)
  );

  // rotation, rounding and saturation
  logic signed [XW-1:0] xr;
  logic [XW-1:0]        xmag;
  logic [PW-1:0] xc_d, ys_d, xs_d, yc_d;
  logic [PW-1:0] xc_q, ys_q, xs_q, yc_q;
  logic signed [SW-1:0] rx_d, ry_d;
  logic signed [SW-1:0] rx_q, ry_q;
  logic [SW-1:0]        mx_w, my_w;
  logic [SW-1:0]        sx_w, sy_w;
  logic [MagW-1:0]      mx_q, my_q;
  logic                 nx_q, ny_q;
  logic signed [VW-1:0] vx_w, vy_w;
  logic                 ovx, ovy;
  tcp_pkg::res_t        res_d, res_q;
  tcp_pkg::side_t       side_r;

  function automatic logic signed [SW-1:0] sterm(input logic [PW-1:0] mag, input logic neg);
    logic signed [SW-1:0] v;
    v = $signed({2'b00, mag});
    return neg ? -v : v;
  endfunction

  assign xr   = side_q[tcp_pkg::StY].x;
  assign xmag = xr[XW-1] ? $unsigned(-xr) : $unsigned(xr);
  assign xc_d = xmag[CW-1:0] * cu_dly_q[tcp_pkg::UDly-1];
  assign xs_d = xmag[CW-1:0] * su_dly_q[tcp_pkg::UDly-1];
  assign ys_d = y_root * su_dly_q[tcp_pkg::UDly-1];
  assign yc_d = y_root * cu_dly_q[tcp_pkg::UDly-1];

  always_comb begin
    logic xn, dxn, dyn, cwb;
    xn  = side_q[tcp_pkg::StR1].x[XW-1];
    dxn = side_q[tcp_pkg::StR1].dx_neg;
    dyn = side_q[tcp_pkg::StR1].dy_neg;
    cwb = side_q[tcp_pkg::StR1].cw;
    rx_d = sterm(xc_q, xn ^ dxn) - sterm(ys_q, cwb ^ dyn);
    ry_d = sterm(xs_q, xn ^ dyn) + sterm(yc_q, cwb ^ dxn);
  end

  assign mx_w = rx_q[SW-1] ? $unsigned(-rx_q) : $unsigned(rx_q);
  assign my_w = ry_q[SW-1] ? $unsigned(-ry_q) : $unsigned(ry_q);
  assign sx_w = mx_w + (SW'(1) << (tcp_pkg::UnitBits - 1));
  assign sy_w = my_w + (SW'(1) << (tcp_pkg::UnitBits - 1));

  assign side_r = side_q[tcp_pkg::StR3];
  assign vx_w = $signed({{(VW-CW){side_r.px[CW-1]}}, side_r.px})
              + (nx_q ? -$signed({2'b00, mx_q}) : $signed({2'b00, mx_q}));
  assign vy_w = $signed({{(VW-CW){side_r.py[CW-1]}}, side_r.py})
              + (ny_q ? -$signed({2'b00, my_q}) : $signed({2'b00, my_q}));
  assign ovx = (|vx_w[VW-1:CW-1]) && !(&vx_w[VW-1:CW-1]);
  assign ovy = (|vy_w[VW-1:CW-1]) && !(&vy_w[VW-1:CW-1]);

  always_comb begin
    res_d.x = ovx ? (vx_w[VW-1] ? tcp_pkg::CoordMin : tcp_pkg::CoordMax) : vx_w[CW-1:0];
    res_d.y = ovy ? (vy_w[VW-1] ? tcp_pkg::CoordMin : tcp_pkg::CoordMax) : vy_w[CW-1:0];
    if (side_r.degen) begin
      res_d.x      = side_r.px;
      res_d.y      = side_r.py;
      res_d.status = tcp_pkg::StatDegen;
    end else if (ovx || ovy) begin
      res_d.status = tcp_pkg::StatSat;
    end else if (side_r.clamp) begin
      res_d.status = tcp_pkg::StatClamp;
    end else begin
      res_d.status = tcp_pkg::StatOk;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[tcp_pkg::StIn] <= side_in;
      for (int k = tcp_pkg::StIn + 1; k <= tcp_pkg::StLast; k++) begin
        side_q[k] <= (k == tcp_pkg::StA) ? side_a : side_q[k-1];
      end
      a1_q     <= a_w;
      diff1_q  <= diff_w;
      a2_q     <= a1_q;
      prodt2_q <= side_q[tcp_pkg::StIn].q * diff1_q;
      uxsq2_q  <= side_q[tcp_pkg::StIn].ux * side_q[tcp_pkg::StIn].ux;
      uysq2_q  <= side_q[tcp_pkg::StIn].uy * side_q[tcp_pkg::StIn].uy;
      dvd3_q   <= {1'b0, prodt2_q} + {{(tcp_pkg::DvdW-CW+1){1'b0}}, a2_q[CW-1:1]};
      dvs3_q   <= a2_q;
      sumsq3_q <= {2'b00, uxsq2_q} + {2'b00, uysq2_q};
      bmx_q    <= clamp_w ? '0 : bmx_w[CW-1:0];
      bpx_q    <= clamp_w ? '0 : bpx_w[CW:0];
      lo1_q    <= bmx_q * bpx_q[CW-1:0];
      hi1_q    <= bpx_q[CW] ? bmx_q : '0;
      rady2_q  <= lo1_q + {hi1_q, {CW{1'b0}}};
      cu_dly_q[0] <= cu_quo;
      su_dly_q[0] <= su_quo;
      for (int k = 1; k < tcp_pkg::UDly; k++) begin
        cu_dly_q[k] <= cu_dly_q[k-1];
        su_dly_q[k] <= su_dly_q[k-1];
      end
      xc_q  <= xc_d;
      ys_q  <= ys_d;
      xs_q  <= xs_d;
      yc_q  <= yc_d;
      rx_q  <= rx_d;
      ry_q  <= ry_d;
      mx_q  <= sx_w[SW-1:tcp_pkg::UnitBits];
      my_q  <= sy_w[SW-1:tcp_pkg::UnitBits];
      nx_q  <= rx_q[SW-1];
      ny_q  <= ry_q[SW-1];
      res_q <= res_d;
    end
  end

  // output register and skid
  logic          out_vld_q, skid_vld_q;
  tcp_pkg::res_t out_q, skid_q;
  logic          leave;

  assign en         = !skid_vld_q;
  assign in_ready_o = en;
  assign leave      = en && vld_q[tcp_pkg::StLast];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (en) begin
        vld_q <= {vld_q[tcp_pkg::StLast-1:tcp_pkg::StIn], in_valid_i};
      end
      if (!out_vld_q || out_ready_i) begin
        out_vld_q  <= skid_vld_q || leave;
        skid_vld_q <= 1'b0;
      end else if (leave) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || out_ready_i) begin
      out_q <= skid_vld_q ? skid_q : res_q;
    end else if (leave) begin
      skid_q <= res_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign new_x_o     = out_q.x;
  assign new_y_o     = out_q.y;
  assign status_o    = out_q.status;

  logic chk_a_live;
  logic chk_res_sat;
  logic chk_at_lim;

  assign chk_a_live  = vld_q[tcp_pkg::StA] && !side_q[tcp_pkg::StA].degen;
  assign chk_res_sat = vld_q[tcp_pkg::StLast] && (res_q.status == tcp_pkg::StatSat);
  assign chk_at_lim  = (res_q.x == tcp_pkg::CoordMax) || (res_q.x == tcp_pkg::CoordMin) ||
                       (res_q.y == tcp_pkg::CoordMax) || (res_q.y == tcp_pkg::CoordMin);

  `TCP_ASSERT_IMPL(a_skid_needs_out, skid_vld_q, out_vld_q)
  `TCP_ASSERT_NEXT(a_skid_fill, out_vld_q && !out_ready_i && leave, skid_vld_q && !in_ready_o)
  `TCP_ASSERT_IMPL(a_no_root_clamp, chk_a_live, !side_q[tcp_pkg::StA].clamp)
  `TCP_ASSERT_IMPL(a_sat_at_limit, chk_res_sat, chk_at_lim)

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for tangent_circle_placer: directed and random placements.
// Depends on tcp_pkg and the tangent_circle_placer RTL; compares results to a local predictor.
`timescale 1ns / 1ps

module tb_top;

  localparam int IdleLimit = 4000;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              in_valid_i = 1'b0;
  logic                              in_ready_o;
  logic signed [tcp_pkg::CoordW-1:0] pivot_x_i = '0;
  logic signed [tcp_pkg::CoordW-1:0] pivot_y_i = '0;
  logic signed [tcp_pkg::CoordW-1:0] neighbor_x_i = '0;
  logic signed [tcp_pkg::CoordW-1:0] neighbor_y_i = '0;
  logic [tcp_pkg::RadW-1:0]          pivot_rad_i = '0;
  logic [tcp_pkg::RadW-1:0]          neighbor_rad_i = '0;
  logic [tcp_pkg::RadW-1:0]          new_rad_i = '0;
  logic                              clockwise_i = 1'b0;
  logic                              out_valid_o;
  logic                              out_ready_i = 1'b0;
  logic signed [tcp_pkg::CoordW-1:0] new_x_o;
  logic signed [tcp_pkg::CoordW-1:0] new_y_o;
  logic [1:0]                        status_o;

  tcp_pkg::res_t placements_due[$];
  int   mismatches = 0;
  int   placed = 0;
  int   checked = 0;
  int   stalled = 0;
  int   degen_seen = 0;
  int   sat_seen = 0;
  bit   no_idle = 1'b0;
  bit   in_ready_seen = 1'b0;

  always #5 clk_i = ~clk_i;

  tangent_circle_placer i_dut (.*);

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [127:0] round_unit(input logic signed [127:0] v);
    logic [127:0] m;
    m = (v < 0) ? -v : v;
    m = (m + (128'd1 << (tcp_pkg::UnitBits - 1))) >> tcp_pkg::UnitBits;
    return (v < 0) ? -$signed(m) : $signed(m);
  endfunction

  function automatic tcp_pkg::res_t place_circle(
    input logic signed [tcp_pkg::CoordW-1:0] px, py, nx, ny,
    input logic [tcp_pkg::RadW-1:0] p, n, q, input logic cw);
    longint dx, dy, t, bmx, bpx, x, y;
    logic [63:0] a, diff, tm, ux, uy, d, cu_m, su_m;
    logic signed [127:0] xw, yw, cw_v, sw_v, ox, oy;
    logic signed [127:0] hi, lo;
    tcp_pkg::res_t r;
    hi = 128'sd2147483647;
    lo = -128'sd2147483648;
    dx = longint'(nx) - longint'(px);
    dy = longint'(ny) - longint'(py);
    a = 64'(p) + 64'(n);
    r.status = tcp_pkg::StatOk;
    if (a == 0 || (dx == 0 && dy == 0)) begin
      r.x = px;
      r.y = py;
      r.status = tcp_pkg::StatDegen;
      return r;
    end
    diff = (p >= n) ? 64'(p) - 64'(n) : 64'(n) - 64'(p);
    tm = (64'(q) * diff + a / 2) / a;
    t = (p >= n) ? longint'(tm) : -longint'(tm);
    x = longint'(64'(p)) + t;
    bmx = longint'(64'(q)) - t;
    bpx = 2 * longint'(64'(p)) + longint'(64'(q)) + t;
    if (bmx < 0 || bpx < 0) begin
      y = 0;
      r.status = tcp_pkg::StatClamp;
    end else begin
      y = longint'(isqrt(64'(bmx) * 64'(bpx)));
    end
    if (cw) y = -y;
    ux = (dx < 0) ? -dx : dx;
    uy = (dy < 0) ? -dy : dy;
    while (((ux | uy) >> 31) != 0) begin
      ux = ux >> 1;
      uy = uy >> 1;
    end
    d = isqrt(ux * ux + uy * uy);
    cu_m = (ux << tcp_pkg::UnitBits) / d;
    su_m = (uy << tcp_pkg::UnitBits) / d;
    cw_v = (dx < 0) ? -$signed({64'd0, cu_m}) : $signed({64'd0, cu_m});
    sw_v = (dy < 0) ? -$signed({64'd0, su_m}) : $signed({64'd0, su_m});
    xw = x;
    yw = y;
    ox = 128'(px) + round_unit(xw * cw_v - yw * sw_v);
    oy = 128'(py) + round_unit(xw * sw_v + yw * cw_v);
    if (ox > hi || ox < lo || oy > hi || oy < lo) r.status = tcp_pkg::StatSat;
    r.x = (ox > hi) ? tcp_pkg::CoordMax : (ox < lo) ? tcp_pkg::CoordMin
                                                    : ox[tcp_pkg::CoordW-1:0];
    r.y = (oy > hi) ? tcp_pkg::CoordMax : (oy < lo) ? tcp_pkg::CoordMin
                                                    : oy[tcp_pkg::CoordW-1:0];
    return r;
  endfunction

  always @(negedge clk_i) in_ready_seen <= in_ready_o;

  task automatic send_placement(
    input logic signed [tcp_pkg::CoordW-1:0] px, py, nx, ny,
    input logic [tcp_pkg::RadW-1:0] p, n, q, input logic cw);
    while (!no_idle && $urandom_range(99) < 19) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    pivot_x_i      <= px;
    pivot_y_i      <= py;
    neighbor_x_i   <= nx;
    neighbor_y_i   <= ny;
    pivot_rad_i    <= p;
    neighbor_rad_i <= n;
    new_rad_i      <= q;
    clockwise_i    <= cw;
    do @(posedge clk_i); while (!in_ready_seen);
    placements_due = {placements_due, place_circle(px, py, nx, ny, p, n, q, cw)};
    placed++;
  endtask

  always @(posedge clk_i) out_ready_i <= no_idle || ($urandom_range(99) >= 19);

  always @(negedge clk_i) begin
    tcp_pkg::res_t due;
    if (rst_ni && out_valid_o && out_ready_i) begin
      checked++;
      if (placements_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result x=%0d y=%0d st=%0d",
                                       new_x_o, new_y_o, status_o);
      end else begin
        due = placements_due.pop_front();
        if (due.status == tcp_pkg::StatDegen) degen_seen++;
        if (due.status == tcp_pkg::StatSat) sat_seen++;
        if (new_x_o !== due.x || new_y_o !== due.y || status_o !== due.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp x=%0d y=%0d st=%0d, got x=%0d y=%0d st=%0d",
                     due.x, due.y, due.status, new_x_o, new_y_o, status_o);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stalled <= 0;
    end else if (stalled >= IdleLimit) begin
      $display("tangent_circle_placer regression: fail");
      $finish;
    end else begin
      stalled <= stalled + 1;
    end
  end

  function automatic logic signed [tcp_pkg::CoordW-1:0] near_coord();
    logic [tcp_pkg::CoordW-1:0] v;
    v = $urandom_range(0, 1 << 21);
    return $signed(v - (1 << 20));
  endfunction

  function automatic logic [tcp_pkg::RadW-1:0] rand_rad(input bit full);
    logic [31:0] v;
    v = full ? $urandom : $urandom_range(0, 1 << 22);
    return v[tcp_pkg::RadW-1:0];
  endfunction

  task automatic test_degenerate();
    send_placement(100, -200, 100, -200, 31'h10000, 31'h20000, 31'h8000, 1'b0);
    send_placement(5, 5, 70000, 9, 0, 0, 31'h1000, 1'b1);
    send_placement(tcp_pkg::CoordMin, tcp_pkg::CoordMax, tcp_pkg::CoordMin, tcp_pkg::CoordMax,
                   '1, '1, '1, 1'b1);
    send_placement(0, 0, 0, 0, 0, 0, 0, 1'b0);
  endtask

  task automatic test_extremes();
    send_placement(0, 0, 31'h20000, 0, 31'h10000, 31'h10000, 31'h10000, 1'b0);
    send_placement(0, 0, 31'h20000, 0, 31'h10000, 31'h10000, 31'h10000, 1'b1);
    send_placement(0, 0, 0, -32'sh30000, 31'h10000, 31'h20000, 0, 1'b0);
    send_placement(1000, 1000, -5000, 3000, 31'h3000, 0, 31'h2000, 1'b1);
    send_placement(-7, 3, 9, -11, 0, 31'h10, '1, 1'b0);
    send_placement(0, 0, 1, 1, '1, 0, '1, 1'b1);
    send_placement(0, 0, -1, 0, 1, '1, '1, 1'b0);
    send_placement(tcp_pkg::CoordMin, tcp_pkg::CoordMin, tcp_pkg::CoordMax, tcp_pkg::CoordMax,
                   31'h100, 31'h100, 31'h100, 1'b0);
    send_placement(tcp_pkg::CoordMax, tcp_pkg::CoordMin, tcp_pkg::CoordMin, tcp_pkg::CoordMax,
                   '1, '1, '1, 1'b1);
    send_placement(0, 0, tcp_pkg::CoordMax, 1, 31'h40, 31'h7fff, 31'h1, 1'b0);
  endtask

  task automatic test_saturation();
    send_placement(tcp_pkg::CoordMax, tcp_pkg::CoordMax, tcp_pkg::CoordMax - 1,
                   tcp_pkg::CoordMax, 31'h7000_0000, 31'h1000, 31'h7000_0000, 1'b0);
    send_placement(tcp_pkg::CoordMin, tcp_pkg::CoordMin, tcp_pkg::CoordMin + 5,
                   tcp_pkg::CoordMin, 31'h100, '1, '1, 1'b1);
    send_placement(tcp_pkg::CoordMax, 0, tcp_pkg::CoordMax, 7, '1, '1, '1, 1'b0);
    send_placement(0, tcp_pkg::CoordMin, 3, tcp_pkg::CoordMin, '1, 31'h1, 31'h4000_0000, 1'b1);
  endtask

  task automatic test_random(input int count, input bit wide);
    logic signed [tcp_pkg::CoordW-1:0] px, py, nx, ny;
    logic [tcp_pkg::RadW-1:0] p, n, q;
    bit full;
    bit cw_b;
    for (int i = 0; i < count; i++) begin
      full = wide || ($urandom_range(9) == 0);
      if (full) begin
        px = $urandom; py = $urandom; nx = $urandom; ny = $urandom;
      end else begin
        px = near_coord(); py = near_coord(); nx = near_coord(); ny = near_coord();
      end
      p = rand_rad(full);
      n = rand_rad(full);
      q = rand_rad(full);
      case ($urandom_range(19))
        0: begin nx = px; ny = py; end
        1: begin p = 0; n = 0; end
        2: q = 0;
        3: n = p;
        default: ;
      endcase
      cw_b = ($urandom_range(1) != 0);
      send_placement(px, py, nx, ny, p, n, q, cw_b);
    end
  endtask

  task automatic test_no_idle();
    no_idle = 1'b1;
    test_random(200, 1'b0);
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_degenerate();
    test_extremes();
    test_saturation();
    test_random(800, 1'b0);
    test_no_idle();
    test_random(380, 1'b1);
    in_valid_i <= 1'b0;
    while (placements_due.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("placed %0d circles, checked %0d results (%0d degenerate, %0d saturated)",
             placed, checked, degen_seen, sat_seen);
    $display("coverage: directed corners, local and full-range random, back-to-back burst");
    if (mismatches == 0 && placements_due.size() == 0)
      $display("tangent_circle_placer regression: pass");
    else
      $display("tangent_circle_placer regression: fail");
    $finish;
  end

endmodule

// File: tangent_circle_placer.f
+incdir+rtl
rtl/tcp_pkg.sv
rtl/tcp_div.sv
rtl/tcp_sqrt.sv
rtl/tangent_circle_placer.sv
sim/tb_top.sv
